### rtl/core/kmcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_pkg: shared types and constants of the keypad change detector
// Key count, command codes, the job word passed from front to back, and
// the lowest-set-bit encoder used by the event sequencer.
// ----------------------------------------------------------------------------
package kmcd_pkg;

  localparam int unsigned KEY_COUNT = 16;
  localparam int unsigned KEY_IDX_W = 4;
  localparam int unsigned KEY_NUM_W = 5;

  // Command codes carried in func
  typedef enum logic {
    FUNC_SNAPSHOT = 1'b0,
    FUNC_CLEAR    = 1'b1
  } func_t;

  // One queued snapshot: keys that fire and the snapshot they fire from
  typedef struct packed {
    logic [KEY_COUNT-1:0] changes;
    logic [KEY_COUNT-1:0] snap;
  } job_t;

  // Index of the lowest set bit (mask must be nonzero for a meaningful result)
  function automatic logic [KEY_IDX_W-1:0] lowest_index(input logic [KEY_COUNT-1:0] mask);
    logic [KEY_COUNT-1:0] one_hot;
    logic [KEY_IDX_W-1:0] idx;
    one_hot = mask & (~mask + 1'b1);
    idx = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (one_hot[i]) begin
        idx = idx | KEY_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/kmcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_in_if / kmcd_out_if: valid/ready channels of the change detector
// Input carries a command or key snapshot; output carries one key event.
// ----------------------------------------------------------------------------
interface kmcd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] key_bits;

  modport source (output valid, output func, output key_bits, input ready);
  modport sink   (input valid, input func, input key_bits, output ready);
endinterface

interface kmcd_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] key_number;
  logic       released;
  logic       last_event;

  modport source (output valid, output key_number, output released, output last_event,
                  input ready);
  modport sink   (input valid, input key_number, input released, input last_event,
                  output ready);
endinterface

### rtl/core/kmcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_front: command decode and key state update
// Takes each word, updates stored key state and lockouts at once, and
// hands the set of firing keys to the event queue.
// ----------------------------------------------------------------------------
module kmcd_front (
  input  logic           clk,
  input  logic           rst,
  kmcd_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           q_push,
  output kmcd_pkg::job_t q_job
);

  logic [kmcd_pkg::KEY_COUNT-1:0] stable_keys;
  logic [kmcd_pkg::KEY_COUNT-1:0] key_locked;
  logic [kmcd_pkg::KEY_COUNT-1:0] changes;
  logic                           accept;
  logic                           is_snap;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_snap     = (kmcd_pkg::func_t'(in_ch.func) == kmcd_pkg::FUNC_SNAPSHOT);

  // Unlocked keys that differ from the stored state
  assign changes = (stable_keys ^ in_ch.key_bits) & ~key_locked;

  assign q_push        = accept && is_snap && (changes != '0);
  assign q_job.changes = changes;
  assign q_job.snap    = in_ch.key_bits;

  // Key state and lockout marks
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_keys <= '0;
      key_locked  <= '0;
    end else if (accept) begin
      if (is_snap) begin
        stable_keys <= (in_ch.key_bits & ~key_locked) | (stable_keys & key_locked);
        key_locked  <= key_locked | changes;
      end else begin
        key_locked  <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // Locked keys never change their stored value on a snapshot
  a_locked_hold: assert property (@(posedge clk) disable iff (rst)
    accept && is_snap |=> ((stable_keys ^ $past(stable_keys)) & $past(key_locked)) == '0)
    else $error("locked key changed stored state");

  // A push only happens with room in the queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule

### rtl/core/kmcd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_fifo: small job queue between front and back
// Register-based circular buffer with occupancy count.
// ----------------------------------------------------------------------------
module kmcd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kmcd_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output kmcd_pkg::job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  kmcd_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

### rtl/core/kmcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_back: key event sequencer
// Walks the firing keys of one job from lowest to highest, one event word
// per cycle when output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module kmcd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  kmcd_pkg::job_t q_head,
  output logic           q_pop,
  kmcd_out_if.source     out_ch
);

  logic                           busy;
  logic [kmcd_pkg::KEY_COUNT-1:0] mask;
  logic [kmcd_pkg::KEY_COUNT-1:0] snap;
  logic [kmcd_pkg::KEY_COUNT-1:0] mask_next;
  logic [kmcd_pkg::KEY_IDX_W-1:0] idx;
  logic                           advance;
  logic                           emit;
  logic                           is_last;
  logic                           o_valid;
  logic [kmcd_pkg::KEY_NUM_W-1:0] o_key_number;
  logic                           o_released;
  logic                           o_last;

  assign advance   = !o_valid || out_ch.ready;
  assign emit      = busy && advance;
  assign idx       = kmcd_pkg::lowest_index(mask);
  assign mask_next = mask & (mask - 1'b1);
  assign is_last   = (mask_next == '0);
  assign q_pop     = q_valid && (!busy || (emit && is_last));

  // Job walker
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (emit && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mask <= q_head.changes;
      snap <= q_head.snap;
    end else if (emit) begin
      mask <= mask_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_key_number <= kmcd_pkg::KEY_NUM_W'(idx) + 1'b1;
      o_released   <= !snap[idx];
      o_last       <= is_last;
    end
  end

  assign out_ch.valid      = o_valid;
  assign out_ch.key_number = o_key_number;
  assign out_ch.released   = o_released;
  assign out_ch.last_event = o_last;

`ifndef SYNTHESIS
  // An active job always has a key left to report
  a_busy_mask: assert property (@(posedge clk) disable iff (rst)
    busy |-> mask != '0)
    else $error("sequencer busy with empty mask");

  // Each emitted event clears exactly one key from the job
  a_one_key: assert property (@(posedge clk) disable iff (rst)
    emit && !is_last |=> busy && $countones(mask) == $countones($past(mask)) - 1)
    else $error("event did not retire one key");

  // An emitted event shows up as valid output on the next cycle
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    emit |=> o_valid)
    else $error("event lost at output stage");
`endif

endmodule

### rtl/core/keypad_matrix_change_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_change_detector_core: 4x4 keypad change detector
// Reports per-key press/release events with per-key lockout.
// ----------------------------------------------------------------------------
// Each input word is a 16-key snapshot or a clear-lockouts command. Stored
// key state and lockouts update in the cycle the word is taken, so words may
// arrive back to back; a snapshot's firing keys are queued (QUEUE_DEPTH jobs)
// and the event sequencer emits one event word per cycle while the output
// is accepted, lowest key first, with last_event on the final one. A
// snapshot yields one event per changed key (0 to 16); input stalls only
// when the job queue is full. No clearing pass after reset.
module keypad_matrix_change_detector_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  kmcd_in_if.sink    in_ch,
  kmcd_out_if.source out_ch
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  kmcd_pkg::job_t q_job;
  kmcd_pkg::job_t q_head;

  // Decode and state update
  kmcd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  // Job queue
  kmcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Event sequencer
  kmcd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
